/* rtl/protobuf_wire_field_parser_macros.svh */
`ifndef PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PWF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pwf_pkg.sv */
package pwf_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int MSG_LEN_BITS          = 24;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED = 3'd2;
    localparam logic [2:0] ERR_SHORT_FIX = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;
    localparam logic [2:0] ERR_BAD_TYPE  = 3'd5;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [2:0]  error_code;
        logic        message_done;
    } rec_t;

endpackage

/* rtl/pwf_core.sv */
module pwf_core #(
    parameter int POSITION_BITS = pwf_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  logic [7:0]                        in_byte,
    input  logic [pwf_pkg::MSG_LEN_BITS-1:0]  msg_len,
    output logic                              rec_valid,
    output pwf_pkg::rec_t                     rec
);

    localparam int LW = (POSITION_BITS > pwf_pkg::MSG_LEN_BITS) ? POSITION_BITS
                                                                : pwf_pkg::MSG_LEN_BITS;

    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_VARINT  = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    logic [2:0]               phase_reg, phase_next;
    logic [63:0]              acc_reg, acc_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic [31:0]              fn_reg, fn_next;
    logic [2:0]               wt_reg, wt_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] left_reg, left_next;

    logic [LW-1:0]            len_ext;
    logic [POSITION_BITS-1:0] len;
    logic [POSITION_BITS:0]   pos_plus;
    logic                     last;
    logic [POSITION_BITS-1:0] remaining;
    logic [POSITION_BITS-1:0] need;
    logic [POSITION_BITS-1:0] left_dec;
    logic [6:0]               sh7;
    logic [63:0]              acc_or;
    logic [63:0]              acc_fix;
    logic [3:0]               cnt_inc;
    logic [31:0]              efn;
    logic [2:0]               ewt;
    logic [31:0]              tag_fn;
    logic [2:0]               tag_wt;
    logic                     overrun;

    function automatic pwf_pkg::rec_t make_rec(logic [1:0] kind, logic [31:0] fn,
                                               logic [2:0] wt, logic [63:0] val,
                                               logic [2:0] err, logic done);
        pwf_pkg::rec_t r;
        r.record_kind  = kind;
        r.field_number = fn;
        r.wire_type    = wt;
        r.value        = val;
        r.error_code   = err;
        r.message_done = done;
        return r;
    endfunction

    assign len_ext   = LW'(msg_len);
    assign len       = len_ext[POSITION_BITS-1:0];
    assign pos_plus  = {1'b0, pos_reg} + (POSITION_BITS+1)'(1);
    assign last      = pos_plus >= {1'b0, len};
    assign remaining = last ? '0 : (len - pos_reg - POSITION_BITS'(1));
    assign need      = (tag_wt == pwf_pkg::WT_FIXED64) ? POSITION_BITS'(8)
                                                       : POSITION_BITS'(4);
    assign left_dec  = (left_reg != '0) ? (left_reg - POSITION_BITS'(1)) : left_reg;

    // varint: 7 bits per byte, bits past 63 drop
    assign sh7     = 7'(cnt_reg) * 7'd7;
    assign acc_or  = (sh7 < 7'd64) ? (acc_reg | (64'(in_byte[6:0]) << sh7[5:0])) : acc_reg;
    assign acc_fix = acc_reg | (64'(in_byte) << {cnt_reg[2:0], 3'b000});
    assign cnt_inc = cnt_reg + 4'd1;

    assign efn     = (phase_reg == PH_TAG) ? 32'd0 : fn_reg;
    assign ewt     = (phase_reg == PH_TAG) ? 3'd0 : wt_reg;
    assign tag_fn  = acc_or[34:3];
    assign tag_wt  = acc_or[2:0];
    assign overrun = (|acc_or[63:POSITION_BITS]) || (acc_or[POSITION_BITS-1:0] > remaining);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        fn_next    = fn_reg;
        wt_next    = wt_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        rec_valid  = 1'b0;
        rec        = '0;

        if (step && (len != '0)) begin
            unique case (phase_reg)
                PH_TAG, PH_VARINT, PH_LEN: begin
                    acc_next = acc_or;
                    if (in_byte[7]) begin
                        cnt_next = cnt_inc;
                        if (cnt_inc > 4'd10) begin
                            rec_valid  = 1'b1;
                            rec        = make_rec(pwf_pkg::KIND_ERROR, efn, ewt, 64'd0,
                                                  pwf_pkg::ERR_TOO_LONG, last);
                            phase_next = PH_DISCARD;
                        end else if (last) begin
                            rec_valid  = 1'b1;
                            rec        = make_rec(pwf_pkg::KIND_ERROR, efn, ewt, 64'd0,
                                                  pwf_pkg::ERR_TRUNCATED, last);
                            phase_next = PH_DISCARD;
                        end
                    end else if (phase_reg == PH_TAG) begin
                        fn_next   = tag_fn;
                        wt_next   = tag_wt;
                        acc_next  = '0;
                        cnt_next  = '0;
                        left_next = '0;
                        if (tag_wt == pwf_pkg::WT_VARINT || tag_wt == pwf_pkg::WT_LEN) begin
                            if (last) begin
                                rec_valid  = 1'b1;
                                rec        = make_rec(pwf_pkg::KIND_ERROR, tag_fn, tag_wt,
                                                      64'd0, pwf_pkg::ERR_TRUNCATED, last);
                                phase_next = PH_DISCARD;
                            end else begin
                                phase_next = (tag_wt == pwf_pkg::WT_VARINT) ? PH_VARINT
                                                                            : PH_LEN;
                            end
                        end else if (tag_wt == pwf_pkg::WT_FIXED64 ||
                                     tag_wt == pwf_pkg::WT_FIXED32) begin
                            if (remaining < need) begin
                                rec_valid  = 1'b1;
                                rec        = make_rec(pwf_pkg::KIND_ERROR, tag_fn, tag_wt,
                                                      64'd0, pwf_pkg::ERR_SHORT_FIX, last);
                                phase_next = PH_DISCARD;
                            end else begin
                                left_next  = need;
                                phase_next = PH_FIXED;
                            end
                        end else begin
                            rec_valid  = 1'b1;
                            rec        = make_rec(pwf_pkg::KIND_ERROR, tag_fn, tag_wt,
                                                  64'd0, pwf_pkg::ERR_BAD_TYPE, last);
                            phase_next = PH_DISCARD;
                        end
                    end else if (phase_reg == PH_VARINT) begin
                        rec_valid  = 1'b1;
                        rec        = make_rec(pwf_pkg::KIND_SCALAR, fn_reg, wt_reg, acc_or,
                                              pwf_pkg::ERR_NONE, last);
                        acc_next   = '0;
                        cnt_next   = '0;
                        left_next  = '0;
                        phase_next = PH_TAG;
                    end else begin
                        acc_next  = '0;
                        cnt_next  = '0;
                        left_next = '0;
                        rec_valid = 1'b1;
                        if (overrun) begin
                            rec        = make_rec(pwf_pkg::KIND_ERROR, fn_reg, wt_reg, 64'd0,
                                                  pwf_pkg::ERR_OVERRUN, last);
                            phase_next = PH_DISCARD;
                        end else begin
                            rec        = make_rec(pwf_pkg::KIND_START, fn_reg, wt_reg, acc_or,
                                                  pwf_pkg::ERR_NONE, last);
                            left_next  = acc_or[POSITION_BITS-1:0];
                            phase_next = (acc_or == 64'd0) ? PH_TAG : PH_PAYLOAD;
                        end
                    end
                end
                PH_FIXED: begin
                    acc_next  = acc_fix;
                    cnt_next  = cnt_inc;
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        rec_valid  = 1'b1;
                        rec        = make_rec(pwf_pkg::KIND_SCALAR, fn_reg, wt_reg, acc_fix,
                                              pwf_pkg::ERR_NONE, last);
                        acc_next   = '0;
                        cnt_next   = '0;
                        left_next  = '0;
                        phase_next = PH_TAG;
                    end
                end
                PH_PAYLOAD: begin
                    rec_valid = 1'b1;
                    rec       = make_rec(pwf_pkg::KIND_PAYLOAD, fn_reg, wt_reg, 64'(in_byte),
                                         pwf_pkg::ERR_NONE, last);
                    left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = PH_TAG;
                    end
                end
                default: begin
                    // drop bytes until the message ends
                end
            endcase

            if (last) begin
                phase_next = PH_TAG;
                acc_next   = '0;
                cnt_next   = '0;
                left_next  = '0;
                fn_next    = '0;
                wt_next    = '0;
                pos_next   = '0;
            end else begin
                pos_next = pos_plus[POSITION_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            fn_reg    <= '0;
            wt_reg    <= '0;
            pos_reg   <= '0;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            fn_reg    <= fn_next;
            wt_reg    <= wt_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
        end
    end

endmodule

/* rtl/protobuf_wire_field_parser.sv */
// Channel  Direction  Handshake            Word
// s_       in         s_valid / s_ready    s_in_byte
// m_       out        m_valid / m_ready    m_record_kind .. m_message_done
// cfg_     in         cfg_valid/cfg_ready  cfg_message_length
//
// One byte per cycle while m_ready stays high; not every byte yields a record on m_.
// Latency is set by the input register and the result register around the
// single decode step. A stalled m_ side holds the result register and then the
// input register; s_ready drops only when both are full. Synchronous reset
// returns the parser to the tag phase and clears message_length.
`include "protobuf_wire_field_parser_macros.svh"

module protobuf_wire_field_parser #(
    parameter int POSITION_BITS = pwf_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_record_kind,
    output logic [31:0]                       m_field_number,
    output logic [2:0]                        m_wire_type,
    output logic [63:0]                       m_value,
    output logic [2:0]                        m_error_code,
    output logic                              m_message_done,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pwf_pkg::MSG_LEN_BITS-1:0]  cfg_message_length
);

    logic                              in_valid_reg, in_valid_next;
    logic [7:0]                        in_byte_reg;
    logic                              out_valid_reg, out_valid_next;
    pwf_pkg::rec_t                     out_rec_reg;
    logic [pwf_pkg::MSG_LEN_BITS-1:0]  msg_len_reg;
    logic                              advance;
    logic                              step;
    logic                              rec_valid;
    pwf_pkg::rec_t                     rec;

    assign advance   = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = rec_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    pwf_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte_reg),
        .msg_len   (msg_len_reg),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            msg_len_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                msg_len_reg <= cfg_message_length;
            end
        end
    end

    // payload registers: load on handshake only
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        if (step && rec_valid) begin
            out_rec_reg <= rec;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_record_kind  = out_rec_reg.record_kind;
    assign m_field_number = out_rec_reg.field_number;
    assign m_wire_type    = out_rec_reg.wire_type;
    assign m_value        = out_rec_reg.value;
    assign m_error_code   = out_rec_reg.error_code;
    assign m_message_done = out_rec_reg.message_done;

    `PWF_ASSERT_NOW(a_err_code_matches_kind, aclk, aresetn, m_valid,
        ((m_record_kind == pwf_pkg::KIND_ERROR) == (m_error_code != pwf_pkg::ERR_NONE)),
        "error code disagrees with record kind")
    `PWF_ASSERT_NOW(a_err_value_zero, aclk, aresetn,
        m_valid && (m_record_kind == pwf_pkg::KIND_ERROR), (m_value == 64'd0),
        "error record carries a value")
    `PWF_ASSERT_NOW(a_payload_is_byte, aclk, aresetn,
        m_valid && (m_record_kind == pwf_pkg::KIND_PAYLOAD), (m_value[63:8] == 56'd0),
        "payload word wider than a byte")
    `PWF_ASSERT_NOW(a_backpressure_only_when_full, aclk, aresetn, !s_ready,
        (in_valid_reg && m_valid && !m_ready), "input stalled without a full pipe")

endmodule

/* verif/protobuf_record_checker.sv */
`timescale 1ns / 100ps

module protobuf_record_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [7:0]                        s_in_byte,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [1:0]                        m_record_kind,
    input  logic [31:0]                       m_field_number,
    input  logic [2:0]                        m_wire_type,
    input  logic [63:0]                       m_value,
    input  logic [2:0]                        m_error_code,
    input  logic                              m_message_done,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [pwf_pkg::MSG_LEN_BITS-1:0]  cfg_message_length,
    output int                                fail_count,
    output int                                outstanding,
    output int                                records_checked,
    output int                                error_records
);

    typedef enum logic [2:0] {
        PARSE_TAG, PARSE_VARINT, PARSE_FIXED, PARSE_LENGTH, PARSE_PAYLOAD, PARSE_DISCARD
    } parse_phase_e;

    logic [pwf_pkg::MSG_LEN_BITS-1:0] msg_len;
    parse_phase_e                     phase;
    logic [63:0]                      acc;
    logic [3:0]                       nbytes;
    logic [31:0]                      fnum;
    logic [2:0]                       wtype;
    logic [23:0]                      pos;
    logic [23:0]                      left;
    pwf_pkg::rec_t                    pending_records[$];

    task automatic queue_record(input logic [1:0] kind, input logic [31:0] fn,
                                input logic [2:0] wt, input logic [63:0] val,
                                input logic [2:0] err, input logic done);
        pwf_pkg::rec_t r;
        r.record_kind  = kind;
        r.field_number = fn;
        r.wire_type    = wt;
        r.value        = val;
        r.error_code   = err;
        r.message_done = done;
        pending_records.insert(pending_records.size(), r);
    endtask

    task automatic clear_field();
        acc    = '0;
        nbytes = '0;
        left   = '0;
    endtask

    task automatic decode_wire_byte(input logic [7:0] b);
        logic        last;
        logic [23:0] remaining;
        logic        in_tag;
        logic [31:0] efn;
        logic [2:0]  ewt;
        logic [63:0] flen;
        logic [3:0]  need;
        int          shift;
        if (msg_len == '0)
            return;
        last      = ({1'b0, pos} + 25'd1 >= {1'b0, msg_len});
        remaining = last ? 24'd0 : msg_len - pos - 24'd1;
        case (phase)
            PARSE_TAG, PARSE_VARINT, PARSE_LENGTH: begin
                in_tag = (phase == PARSE_TAG);
                efn    = in_tag ? 32'd0 : fnum;
                ewt    = in_tag ? 3'd0 : wtype;
                shift  = 7 * nbytes;
                // bits past 63 fall off the top
                if (shift < 64)
                    acc |= {57'd0, b[6:0]} << shift;
                if (b[7]) begin
                    nbytes = nbytes + 4'd1;
                    if (nbytes > 4'd10) begin
                        queue_record(pwf_pkg::KIND_ERROR, efn, ewt, '0,
                                     pwf_pkg::ERR_TOO_LONG, last);
                        phase = PARSE_DISCARD;
                    end else if (last) begin
                        queue_record(pwf_pkg::KIND_ERROR, efn, ewt, '0,
                                     pwf_pkg::ERR_TRUNCATED, last);
                        phase = PARSE_DISCARD;
                    end
                end else if (in_tag) begin
                    wtype = acc[2:0];
                    fnum  = acc[34:3];
                    clear_field();
                    if (wtype == pwf_pkg::WT_VARINT || wtype == pwf_pkg::WT_LEN) begin
                        if (last) begin
                            queue_record(pwf_pkg::KIND_ERROR, fnum, wtype, '0,
                                         pwf_pkg::ERR_TRUNCATED, last);
                            phase = PARSE_DISCARD;
                        end else begin
                            phase = (wtype == pwf_pkg::WT_VARINT) ? PARSE_VARINT
                                                                  : PARSE_LENGTH;
                        end
                    end else if (wtype == pwf_pkg::WT_FIXED64 ||
                                 wtype == pwf_pkg::WT_FIXED32) begin
                        need = (wtype == pwf_pkg::WT_FIXED64) ? 4'd8 : 4'd4;
                        if (remaining < {20'd0, need}) begin
                            queue_record(pwf_pkg::KIND_ERROR, fnum, wtype, '0,
                                         pwf_pkg::ERR_SHORT_FIX, last);
                            phase = PARSE_DISCARD;
                        end else begin
                            left  = {20'd0, need};
                            phase = PARSE_FIXED;
                        end
                    end else begin
                        queue_record(pwf_pkg::KIND_ERROR, fnum, wtype, '0,
                                     pwf_pkg::ERR_BAD_TYPE, last);
                        phase = PARSE_DISCARD;
                    end
                end else if (phase == PARSE_VARINT) begin
                    queue_record(pwf_pkg::KIND_SCALAR, fnum, wtype, acc,
                                 pwf_pkg::ERR_NONE, last);
                    clear_field();
                    phase = PARSE_TAG;
                end else begin
                    flen = acc;
                    clear_field();
                    if (flen > {40'd0, remaining}) begin
                        queue_record(pwf_pkg::KIND_ERROR, fnum, wtype, '0,
                                     pwf_pkg::ERR_OVERRUN, last);
                        phase = PARSE_DISCARD;
                    end else begin
                        queue_record(pwf_pkg::KIND_START, fnum, wtype, flen,
                                     pwf_pkg::ERR_NONE, last);
                        left  = flen[23:0];
                        phase = (flen == 0) ? PARSE_TAG : PARSE_PAYLOAD;
                    end
                end
            end
            PARSE_FIXED: begin
                acc |= {56'd0, b} << ((8 * nbytes) & 63);
                nbytes = nbytes + 4'd1;
                if (left != 0)
                    left = left - 24'd1;
                if (left == 0) begin
                    queue_record(pwf_pkg::KIND_SCALAR, fnum, wtype, acc,
                                 pwf_pkg::ERR_NONE, last);
                    clear_field();
                    phase = PARSE_TAG;
                end
            end
            PARSE_PAYLOAD: begin
                queue_record(pwf_pkg::KIND_PAYLOAD, fnum, wtype, {56'd0, b},
                             pwf_pkg::ERR_NONE, last);
                if (left != 0)
                    left = left - 24'd1;
                if (left == 0)
                    phase = PARSE_TAG;
            end
            default: ;
        endcase
        // rearm at the message boundary
        if (last) begin
            phase = PARSE_TAG;
            clear_field();
            fnum  = '0;
            wtype = '0;
            pos   = '0;
        end else begin
            pos = pos + 24'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        pwf_pkg::rec_t want;
        if (!aresetn) begin
            msg_len = '0;
            phase   = PARSE_TAG;
            clear_field();
            fnum    = '0;
            wtype   = '0;
            pos     = '0;
            pending_records.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_records.size() == 0) begin
                    $error("record with no expectation waiting: kind %0d field %0d",
                           m_record_kind, m_field_number);
                    fail_count++;
                end else begin
                    want = pending_records.pop_front();
                    check_field("record_kind", 64'(want.record_kind), 64'(m_record_kind));
                    check_field("field_number", 64'(want.field_number),
                                64'(m_field_number));
                    check_field("wire_type", 64'(want.wire_type), 64'(m_wire_type));
                    check_field("value", want.value, m_value);
                    check_field("error_code", 64'(want.error_code), 64'(m_error_code));
                    check_field("message_done", 64'(want.message_done),
                                64'(m_message_done));
                    records_checked++;
                    if (want.record_kind == pwf_pkg::KIND_ERROR)
                        error_records++;
                end
            end
            if (cfg_valid && cfg_ready)
                msg_len = cfg_message_length;
            if (s_valid && s_ready)
                decode_wire_byte(s_in_byte);
        end
        outstanding <= pending_records.size();
    end

endmodule

/* verif/tb_protobuf_wire_field_parser.sv */
`timescale 1ns / 100ps

module tb_protobuf_wire_field_parser;

    typedef logic [pwf_pkg::MSG_LEN_BITS-1:0] msg_len_t;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1100;

    logic                    aclk               = 1'b0;
    logic                    aresetn            = 1'b0;
    logic                    s_valid            = 1'b0;
    logic                    s_ready;
    logic [7:0]              s_in_byte          = '0;
    logic                    m_valid;
    logic                    m_ready            = 1'b0;
    logic [1:0]              m_record_kind;
    logic [31:0]             m_field_number;
    logic [2:0]              m_wire_type;
    logic [63:0]             m_value;
    logic [2:0]              m_error_code;
    logic                    m_message_done;
    logic                    cfg_valid          = 1'b0;
    logic                    cfg_ready;
    msg_len_t                cfg_message_length = '0;

    int                      fail_count;
    int                      outstanding;
    int                      records_checked;
    int                      error_records;
    int                      cycle_count        = 0;
    int                      bytes_sent         = 0;
    int                      messages           = 0;
    int                      length_writes      = 0;
    msg_len_t                cur_len            = '0;
    int                      hold_requests      = 0;
    int                      holds_done         = 0;
    logic                    steady_sender      = 1'b0;
    logic [7:0]              msg_q[$];

    protobuf_wire_field_parser dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_byte          (s_in_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_record_kind      (m_record_kind),
        .m_field_number     (m_field_number),
        .m_wire_type        (m_wire_type),
        .m_value            (m_value),
        .m_error_code       (m_error_code),
        .m_message_done     (m_message_done),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_message_length (cfg_message_length)
    );

    protobuf_record_checker record_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_in_byte          (s_in_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_record_kind      (m_record_kind),
        .m_field_number     (m_field_number),
        .m_wire_type        (m_wire_type),
        .m_value            (m_value),
        .m_error_code       (m_error_code),
        .m_message_done     (m_message_done),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_message_length (cfg_message_length),
        .fail_count         (fail_count),
        .outstanding        (outstanding),
        .records_checked    (records_checked),
        .error_records      (error_records)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < LIMIT_CYCLES) @(posedge aclk);
        $error("run did not finish within %0d cycles", LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] pick_field_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 64'($urandom_range(1, 31));
        if (r < 90) return {32'd0, $urandom()};
        // wider than 32 bits: the block keeps the low 32
        return {$urandom(), $urandom()} >> 3;
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 127));
            1: return 64'($urandom_range(128, 65535));
            2: return {$urandom(), $urandom()};
            default: return $urandom_range(0, 1) ? 64'd0 : '1;
        endcase
    endfunction

    task automatic append_byte(input logic [7:0] b);
        msg_q.insert(msg_q.size(), b);
    endtask

    // receiver: random ready pattern, plus one long hold-off on request
    initial begin
        int run_left;
        run_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
                m_ready <= 1'b1;
                run_left = 4;
            end else if (run_left > 0) begin
                run_left--;
            end else if (m_ready) begin
                run_left = pick_gap();
                if (run_left > 0) begin
                    m_ready <= 1'b0;
                    run_left--;
                end
            end else begin
                m_ready <= 1'b1;
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(0, 6);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (cur_len != 0)
            bytes_sent++;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // drop valid, wait for every record, then let the pipeline empty
    task automatic finish_phase();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(input msg_len_t len);
        finish_phase();
        cfg_valid          <= 1'b1;
        cfg_message_length <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_len = len;
        length_writes++;
    endtask

    task automatic send_message(input msg_len_t len);
        if (len != cur_len)
            set_length(len);
        foreach (msg_q[i])
            send_byte(msg_q[i]);
        messages++;
    endtask

    task automatic put_varint(input logic [63:0] v, input int pad);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0 || pad > 0)
                b[7] = 1'b1;
            append_byte(b);
        end while (v != 0);
        // non-minimal encoding: continuation bytes, then a closing zero
        while (pad > 0) begin
            pad--;
            append_byte((pad > 0) ? 8'h80 : 8'h00);
        end
    endtask

    task automatic put_payload_field(input logic [63:0] fn, input int plen);
        put_varint({fn[60:0], pwf_pkg::WT_LEN}, pick_pad());
        put_varint(64'(plen), pick_pad());
        repeat (plen) append_byte(8'($urandom()));
    endtask

    task automatic build_message();
        int          nfields;
        int          kind;
        logic [63:0] fn;
        msg_q.delete();
        nfields = $urandom_range(1, 5);
        repeat (nfields) begin
            fn   = pick_field_number();
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                put_varint({fn[60:0], pwf_pkg::WT_VARINT}, pick_pad());
                if ($urandom_range(0, 9) == 0) begin
                    // ten-byte varint whose top bits go past bit 63
                    repeat (9) append_byte(8'($urandom()) | 8'h80);
                    append_byte(8'($urandom()) & 8'h7f);
                end else begin
                    put_varint(pick_value(), pick_pad());
                end
            end else if (kind < 50) begin
                put_varint({fn[60:0], pwf_pkg::WT_FIXED32}, pick_pad());
                repeat (4) append_byte(8'($urandom()));
            end else if (kind < 65) begin
                put_varint({fn[60:0], pwf_pkg::WT_FIXED64}, pick_pad());
                repeat (8) append_byte(8'($urandom()));
            end else begin
                put_payload_field(fn, ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                                  : $urandom_range(0, 6));
            end
        end
    endtask

    initial begin
        int start_bytes;
        int m;
        int r;
        int k;
        int n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // zero length: bytes are ignored
        set_length('0);
        msg_q = '{8'hff, 8'h00};
        send_message('0);
        // field 1 varint 150
        msg_q = '{8'h08, 8'h96, 8'h01};
        send_message(3);
        // message ends right after a varint tag
        msg_q = '{8'h10};
        send_message(1);
        // fixed32 tag with nothing after it
        msg_q = '{8'h0d};
        send_message(1);
        // bad wire type, then a discarded last byte
        msg_q = '{8'h0b, 8'h5a};
        send_message(2);
        // length past the end
        msg_q = '{8'h12, 8'h05, 8'haa};
        send_message(3);
        // zero-length field
        msg_q = '{8'h1a, 8'h00};
        send_message(2);
        // eleven continuation bytes ending the message: too long wins
        msg_q.delete();
        repeat (11) append_byte(8'hff);
        send_message(11);

        start_bytes = bytes_sent;
        m = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            steady_sender = ($urandom_range(0, 4) == 0);
            if (m == 10) begin
                // fill the block while the receiver holds off
                build_message();
                put_payload_field(pick_field_number(), 160);
                hold_requests++;
                send_message(msg_len_t'(msg_q.size()));
            end else if (m == 20) begin
                // longest message, then cut it short below the current position
                build_message();
                send_message('1);
                set_length(1);
                msg_q = '{8'($urandom())};
                send_message(1);
            end else if (m == 30) begin
                msg_q.delete();
                repeat (5) append_byte(8'($urandom()));
                set_length('0);
                send_message('0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    build_message();
                end else if (r < 85) begin
                    build_message();
                    if ($urandom_range(0, 1)) begin
                        k = $urandom_range(1, msg_q.size());
                        while (msg_q.size() > k) void'(msg_q.pop_back());
                    end else begin
                        msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom());
                    end
                end else begin
                    n = (cur_len != 0 && cur_len <= 24 && $urandom_range(0, 1))
                        ? int'(cur_len) : $urandom_range(1, 20);
                    msg_q.delete();
                    repeat (n) append_byte(8'($urandom()));
                end
                send_message(msg_len_t'(msg_q.size()));
            end
            m++;
        end

        finish_phase();
        $display("Parsed %0d bytes in %0d messages over %0d message-length settings.",
                 bytes_sent, messages, length_writes);
        $display("Compared %0d records, %0d of them error records.",
                 records_checked, error_records);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* protobuf_wire_field_parser.f */
+incdir+rtl
rtl/pwf_pkg.sv
rtl/pwf_core.sv
rtl/protobuf_wire_field_parser.sv
verif/protobuf_record_checker.sv
verif/tb_protobuf_wire_field_parser.sv
